@@ hdl/trial_division_prime_test_assert.svh @@
// Assertion macros used by the RTL of the trial-division prime test.
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TDPT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tdpt assertion failed");

// Next-cycle implication, checked out of reset.
`define TDPT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tdpt assertion failed");

`endif

@@ hdl/tdpt_pkg.sv @@
package tdpt_pkg;

   // Smallest divisor tried, and smallest number that can be prime
   localparam int FIRST_DIVISOR = 2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

@@ hdl/tdpt_if.sv @@
// Request channel: one number to test per transaction
interface tdpt_req_if #(
   parameter int WIDTH = 31
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink (input valid, input number, output ready);
endinterface

// Response channel: one verdict per transaction
interface tdpt_rsp_if;
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink (input valid, input is_prime, output ready);
endinterface

@@ hdl/trial_division_prime_test.sv @@
// Trial-division primality test. Each request transaction carries one unsigned
// WIDTH-bit number; one response transaction returns is_prime (1 for a prime,
// 0 for a composite or for zero and one). The block tries divisors 2, 3, 4 ...
// while divisor <= number / divisor and stops at the first exact divisor. A
// single restoring divider, one quotient bit per cycle, produces both the
// remainder and the quotient used for the bound; each trial divisor goes
// through a load step, WIDTH shift-subtract steps and a check step. Zero
// and one skip the divider and go straight to the response. The block takes
// one request at a time: req.ready is high only while idle, and the response
// is held until the sink takes it.
`include "trial_division_prime_test_assert.svh"

module trial_division_prime_test
   import tdpt_pkg::*;
#(
   parameter int WIDTH = 31
) (
   input  logic           clock,
   input  logic           reset,
   tdpt_req_if.sink       req,
   tdpt_rsp_if.source     rsp
);

   localparam int CNT_W = $clog2(WIDTH);

   state_type            state_ff, state_in;
   logic [WIDTH-1:0]     n_ff, n_in;
   logic [WIDTH-1:0]     d_ff, d_in;
   logic [WIDTH-1:0]     rem_ff, rem_in;
   logic [WIDTH-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 prime_ff, prime_in;

   logic                 req_take;
   logic                 below_two;
   logic                 div_last;
   logic                 bound_hit;
   logic                 exact;
   logic [WIDTH:0]       trial;
   logic [WIDTH:0]       diff;
   logic                 sub_ok;

   // Status terms used by the sequencer and the datapath
   assign req_take  = req.valid && req.ready;
   assign below_two = (req.number[WIDTH-1:1] == '0);
   assign div_last  = (cnt_ff == CNT_W'(WIDTH - 1));
   assign bound_hit = (d_ff > quo_ff);
   assign exact     = (rem_ff == '0);

   // Shared shift-subtract unit: one quotient bit per cycle
   assign trial  = {rem_ff, quo_ff[WIDTH-1]};
   assign diff   = trial - {1'b0, d_ff};
   assign sub_ok = !diff[WIDTH];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = below_two ? ST_DONE : ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (bound_hit || exact) ? ST_DONE : ST_LOAD;
         end
         ST_DONE: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake outputs
   always_comb begin
      req.ready    = (state_ff == ST_IDLE);
      rsp.valid    = (state_ff == ST_DONE);
      rsp.is_prime = prime_ff;
   end

   // Datapath next values
   always_comb begin
      n_in     = n_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      prime_in = prime_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               n_in     = req.number;
               d_in     = WIDTH'(FIRST_DIVISOR);
               prime_in = 1'b0;
            end
         end
         ST_LOAD: begin
            // restart the divider on the current divisor
            rem_in = '0;
            quo_in = n_ff;
            cnt_in = '0;
         end
         ST_DIV: begin
            rem_in = sub_ok ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], sub_ok};
            cnt_in = cnt_ff + 1'b1;
         end
         ST_CHECK: begin
            // divisor past the square root: prime; exact division: composite
            if (bound_hit) begin
               prime_in = 1'b1;
            end else if (exact) begin
               prime_in = 1'b0;
            end else begin
               d_in = d_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      d_ff     <= d_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      prime_ff <= prime_in;
   end

   `TDPT_ASSERT_NOW(a_rem_below_div, (state_ff == ST_DIV || state_ff == ST_CHECK), (rem_ff < d_ff))
   `TDPT_ASSERT_NOW(a_div_min, (state_ff == ST_LOAD || state_ff == ST_CHECK), (d_ff >= WIDTH'(FIRST_DIVISOR)))
   `TDPT_ASSERT_NOW(a_cnt_range, (state_ff == ST_DIV), (cnt_ff <= CNT_W'(WIDTH - 1)))
   `TDPT_ASSERT_NEXT(a_small_not_prime, (req_take && below_two), (state_ff == ST_DONE && !prime_ff))
   `TDPT_ASSERT_NEXT(a_bound_prime, (state_ff == ST_CHECK && bound_hit), (state_ff == ST_DONE && prime_ff))

endmodule
